### hw/rtl/socks5hp_pkg.sv
// Shared types and constants for the SOCKS5 handshake parser.
package socks5hp_pkg;

    typedef logic [3:0] phase_t;

    localparam phase_t PH_VER   = 4'd0;
    localparam phase_t PH_NMETH = 4'd1;
    localparam phase_t PH_METH  = 4'd2;
    localparam phase_t PH_RVER  = 4'd3;
    localparam phase_t PH_CMD   = 4'd4;
    localparam phase_t PH_RSV   = 4'd5;
    localparam phase_t PH_ATYP  = 4'd6;
    localparam phase_t PH_DLEN  = 4'd7;
    localparam phase_t PH_ADDR  = 4'd8;
    localparam phase_t PH_PORTH = 4'd9;
    localparam phase_t PH_PORTL = 4'd10;
    localparam phase_t PH_IDLE  = 4'd11;

    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_ADDR   = 2'd1;
    localparam logic [1:0] KIND_TARGET = 2'd2;

    localparam logic [1:0] ATYPE_IPV4   = 2'd0;
    localparam logic [1:0] ATYPE_DOMAIN = 2'd1;
    localparam logic [1:0] ATYPE_IPV6   = 2'd2;

    localparam logic [7:0] SOCKS_VER       = 8'h05;
    localparam logic [7:0] METHOD_NO_AUTH  = 8'h00;
    localparam logic [7:0] REP_SUCCESS     = 8'h00;
    localparam logic [7:0] REP_NO_METHOD   = 8'hFF;
    localparam logic [7:0] REP_BAD_ATYP    = 8'h08;
    localparam logic [7:0] REP_BAD_CMD     = 8'h07;
    localparam logic [7:0] CMD_CONNECT     = 8'h01;
    localparam logic [7:0] ATYP_CODE_IPV4  = 8'h01;
    localparam logic [7:0] ATYP_CODE_NAME  = 8'h03;
    localparam logic [7:0] ATYP_CODE_IPV6  = 8'h04;
    localparam logic [7:0] IPV4_LEN        = 8'd4;
    localparam logic [7:0] IPV6_LEN        = 8'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [7:0]  addr_index;
        logic [1:0]  addr_type;
        logic [15:0] port;
        logic        last;
    } result_t;

    function automatic result_t reply_byte(input logic [7:0] code, input logic is_last);
        result_t r;
        r = '0;
        r.kind  = KIND_REPLY;
        r.value = code;
        r.last  = is_last;
        return r;
    endfunction

endpackage

### hw/rtl/socks5hp_parser.sv
// Handshake state and per-byte decode; produces up to two result items per byte.
module socks5hp_parser
    import socks5hp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       begin_session,
    output logic [1:0] res_count,
    output result_t    res0,
    output result_t    res1
);

    phase_t     phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] methods_left_reg, methods_left_next;
    logic       no_auth_seen_reg, no_auth_seen_next;
    logic       connect_ok_reg, connect_ok_next;
    logic [1:0] address_type_reg, address_type_next;
    logic [7:0] address_length_reg, address_length_next;
    logic [7:0] port_high_reg, port_high_next;

    phase_t     ph;
    logic [7:0] cnt_inc;
    logic [7:0] meth_dec;

    always_comb
    begin
        // a new session starts from the reset state with this byte
        if (begin_session)
        begin
            ph                  = PH_VER;
            byte_count_next     = '0;
            methods_left_next   = '0;
            no_auth_seen_next   = 1'b0;
            connect_ok_next     = 1'b0;
            address_type_next   = ATYPE_IPV4;
            address_length_next = '0;
            port_high_next      = '0;
        end
        else
        begin
            ph                  = phase_reg;
            byte_count_next     = byte_count_reg;
            methods_left_next   = methods_left_reg;
            no_auth_seen_next   = no_auth_seen_reg;
            connect_ok_next     = connect_ok_reg;
            address_type_next   = address_type_reg;
            address_length_next = address_length_reg;
            port_high_next      = port_high_reg;
        end
        phase_next = ph;
        res_count  = 2'd0;
        res0       = '0;
        res1       = '0;
        cnt_inc    = byte_count_next + 8'd1;
        meth_dec   = methods_left_next - 8'd1;

        unique case (ph)
            PH_VER:
            begin
                if (data_byte != SOCKS_VER)
                begin
                    phase_next = PH_IDLE;
                    res_count  = 2'd2;
                    res0       = reply_byte(SOCKS_VER, 1'b0);
                    res1       = reply_byte(REP_NO_METHOD, 1'b1);
                end
                else
                begin
                    phase_next = PH_NMETH;
                end
            end
            PH_NMETH:
            begin
                methods_left_next = data_byte;
                no_auth_seen_next = 1'b0;
                if (data_byte == 8'd0)
                begin
                    phase_next = PH_IDLE;
                    res_count  = 2'd2;
                    res0       = reply_byte(SOCKS_VER, 1'b0);
                    res1       = reply_byte(REP_NO_METHOD, 1'b1);
                end
                else
                begin
                    phase_next = PH_METH;
                end
            end
            PH_METH:
            begin
                methods_left_next = meth_dec;
                if (data_byte == METHOD_NO_AUTH)
                begin
                    no_auth_seen_next = 1'b1;
                end
                if (meth_dec == 8'd0)
                begin
                    res_count = 2'd2;
                    res0      = reply_byte(SOCKS_VER, 1'b0);
                    if (no_auth_seen_next)
                    begin
                        phase_next = PH_RVER;
                        res1       = reply_byte(REP_SUCCESS, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res1       = reply_byte(REP_NO_METHOD, 1'b1);
                    end
                end
            end
            PH_RVER:
            begin
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                connect_ok_next = (data_byte == CMD_CONNECT);
                phase_next      = PH_RSV;
            end
            PH_RSV:
            begin
                phase_next = PH_ATYP;
            end
            PH_ATYP:
            begin
                priority if (data_byte == ATYP_CODE_IPV4 || data_byte == ATYP_CODE_NAME ||
                             data_byte == ATYP_CODE_IPV6)
                begin
                    priority if (data_byte == ATYP_CODE_IPV4)
                    begin
                        address_type_next   = ATYPE_IPV4;
                        address_length_next = IPV4_LEN;
                    end
                    else if (data_byte == ATYP_CODE_NAME)
                    begin
                        address_type_next = ATYPE_DOMAIN;
                    end
                    else
                    begin
                        address_type_next   = ATYPE_IPV6;
                        address_length_next = IPV6_LEN;
                    end
                    if (!connect_ok_next)
                    begin
                        phase_next = PH_IDLE;
                        res_count  = 2'd2;
                        res0       = reply_byte(SOCKS_VER, 1'b0);
                        res1       = reply_byte(REP_BAD_CMD, 1'b1);
                    end
                    else
                    begin
                        byte_count_next = '0;
                        phase_next = (data_byte == ATYP_CODE_NAME) ? PH_DLEN : PH_ADDR;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    res_count  = 2'd2;
                    res0       = reply_byte(SOCKS_VER, 1'b0);
                    res1       = reply_byte(REP_BAD_ATYP, 1'b1);
                end
            end
            PH_DLEN:
            begin
                address_length_next = data_byte;
                byte_count_next     = '0;
                phase_next          = (data_byte == 8'd0) ? PH_PORTH : PH_ADDR;
            end
            PH_ADDR:
            begin
                res_count       = 2'd1;
                res0.kind       = KIND_ADDR;
                res0.value      = data_byte;
                res0.addr_index = byte_count_next;
                res0.addr_type  = address_type_next;
                res0.last       = 1'b1;
                if (cnt_inc == address_length_next)
                begin
                    phase_next = PH_PORTH;
                end
                byte_count_next = cnt_inc;
            end
            PH_PORTH:
            begin
                port_high_next = data_byte;
                phase_next     = PH_PORTL;
            end
            PH_PORTL:
            begin
                res_count       = 2'd1;
                res0.kind       = KIND_TARGET;
                res0.addr_index = address_length_next;
                res0.addr_type  = address_type_next;
                res0.port       = {port_high_next, data_byte};
                res0.last       = 1'b1;
                phase_next      = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_VER;
            byte_count_reg     <= '0;
            methods_left_reg   <= '0;
            no_auth_seen_reg   <= 1'b0;
            connect_ok_reg     <= 1'b0;
            address_type_reg   <= ATYPE_IPV4;
            address_length_reg <= '0;
            port_high_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            methods_left_reg   <= methods_left_next;
            no_auth_seen_reg   <= no_auth_seen_next;
            connect_ok_reg     <= connect_ok_next;
            address_type_reg   <= address_type_next;
            address_length_reg <= address_length_next;
            port_high_reg      <= port_high_next;
        end
    end

endmodule

### hw/rtl/socks5_connect_handshake_parser_unit.sv
// Top level of the SOCKS5 CONNECT handshake parser: input register, decode, result queue.
//
// Input channel: one client byte per item (data_byte, begin_session) on
// in_valid / in_stall. Raise begin_session with the first byte of a session.
// Output channel: result items (kind, value, addr_index, addr_type, port,
// last) on out_valid / out_stall; last marks the final item caused by a byte.
// A byte is decoded straight out of the input register once the queue has room;
// its results are registered into the queue and offered from there. The
// decode step takes one byte per cycle while it is not waiting and writes up to two results into a
// four-entry queue; the output drains one item per cycle while out_stall is low,
// so a steady stream with no stalls runs at one byte per cycle.
// Decode waits while the queue has fewer than two free slots; in_stall rises
// once the input register is full and cannot move on. A stalled receiver
// thus holds results in the queue and backs up into the input side.
// Reset empties the input register and queue and returns the parser to
// expecting the version byte.
module socks5_connect_handshake_parser_unit
    import socks5hp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        begin_session,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic [7:0]  addr_index,
    output logic [1:0]  addr_type,
    output logic [15:0] port,
    output logic        last
);

    localparam int QDEPTH = 4;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_begin_reg;

    logic       fire;
    logic       accept;
    logic [1:0] res_count;
    result_t    res0;
    result_t    res1;

    result_t    queue_reg [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop;
    result_t    head;

    // decode only when two queue slots are surely free
    assign fire     = hold_valid_reg && (count_reg <= 3'd2);
    assign in_stall = hold_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept || fire)
        begin
            hold_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg  <= data_byte;
            hold_begin_reg <= begin_session;
        end
    end

    socks5hp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .data_byte     (hold_byte_reg),
        .begin_session (hold_begin_reg),
        .res_count     (res_count),
        .res0          (res0),
        .res1          (res1)
    );

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign head      = queue_reg[rd_ptr_reg];

    assign kind       = head.kind;
    assign value      = head.value;
    assign addr_index = head.addr_index;
    assign addr_type  = head.addr_type;
    assign port       = head.port;
    assign last       = head.last;

    always_ff @(posedge clk)
    begin
        if (fire && res_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (fire && res_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + res_count;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (fire ? {1'b0, res_count} : 3'd0) - {2'b00, pop};
        end
    end

endmodule

### verif/socks5_connect_handshake_parser_unit_tb.sv
// Self-checking testbench for the SOCKS5 CONNECT handshake parser: byte streams, predicted replies.
module socks5_connect_handshake_parser_unit_tb;
    import socks5hp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_START  = 400;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } client_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        begin_session = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [7:0]  addr_index;
    logic [1:0]  addr_type;
    logic [15:0] port;
    logic        last;

    client_byte_t client_bytes[$];
    result_t      pending_results[$];
    int           item_count = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    logic         in_taken = 1'b0;
    logic         calm;

    // parser state as seen by the testbench
    phase_t     parse_phase;
    logic [7:0] addr_count;
    logic [7:0] methods_left;
    logic       no_auth_seen;
    logic       connect_ok;
    logic [1:0] atype;
    logic [7:0] addr_len;
    logic [7:0] port_hi;

    socks5_connect_handshake_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .begin_session (begin_session),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .value         (value),
        .addr_index    (addr_index),
        .addr_type     (addr_type),
        .port          (port),
        .last          (last)
    );

    always #5 clk = ~clk;

    // no idling on either side inside this window
    assign calm = (cycle_count >= 1000) && (cycle_count < 1800);

    task automatic clear_parser();
        parse_phase  = PH_VER;
        addr_count   = 8'd0;
        methods_left = 8'd0;
        no_auth_seen = 1'b0;
        connect_ok   = 1'b0;
        atype        = ATYPE_IPV4;
        addr_len     = 8'd0;
        port_hi      = 8'd0;
    endtask

    task automatic push_result(input logic [1:0] k, input logic [7:0] v, input logic [7:0] idx,
                               input logic [1:0] t, input logic [15:0] p, input logic fin);
        result_t r;
        r.kind       = k;
        r.value      = v;
        r.addr_index = idx;
        r.addr_type  = t;
        r.port       = p;
        r.last       = fin;
        pending_results.push_back(r);
    endtask

    task automatic push_reply(input logic [7:0] code);
        push_result(KIND_REPLY, SOCKS_VER, 8'd0, ATYPE_IPV4, 16'd0, 1'b0);
        push_result(KIND_REPLY, code, 8'd0, ATYPE_IPV4, 16'd0, 1'b1);
    endtask

    task automatic parse_client_byte(input logic [7:0] b, input logic restart);
        if (restart)
            clear_parser();
        case (parse_phase)
            PH_VER:
            begin
                if (b != SOCKS_VER)
                begin
                    parse_phase = PH_IDLE;
                    push_reply(REP_NO_METHOD);
                end
                else
                    parse_phase = PH_NMETH;
            end
            PH_NMETH:
            begin
                methods_left = b;
                no_auth_seen = 1'b0;
                if (b == 8'd0)
                begin
                    parse_phase = PH_IDLE;
                    push_reply(REP_NO_METHOD);
                end
                else
                    parse_phase = PH_METH;
            end
            PH_METH:
            begin
                if (b == METHOD_NO_AUTH)
                    no_auth_seen = 1'b1;
                methods_left = methods_left - 8'd1;
                if (methods_left == 8'd0)
                begin
                    if (no_auth_seen)
                    begin
                        parse_phase = PH_RVER;
                        push_reply(REP_SUCCESS);
                    end
                    else
                    begin
                        parse_phase = PH_IDLE;
                        push_reply(REP_NO_METHOD);
                    end
                end
            end
            PH_RVER:
                parse_phase = PH_CMD;
            PH_CMD:
            begin
                connect_ok  = (b == CMD_CONNECT);
                parse_phase = PH_RSV;
            end
            PH_RSV:
                parse_phase = PH_ATYP;
            PH_ATYP:
            begin
                if (b != ATYP_CODE_IPV4 && b != ATYP_CODE_NAME && b != ATYP_CODE_IPV6)
                begin
                    // address type is judged before the command
                    parse_phase = PH_IDLE;
                    push_reply(REP_BAD_ATYP);
                end
                else
                begin
                    if (b == ATYP_CODE_IPV4)
                    begin
                        atype    = ATYPE_IPV4;
                        addr_len = IPV4_LEN;
                    end
                    else if (b == ATYP_CODE_NAME)
                        atype = ATYPE_DOMAIN;
                    else
                    begin
                        atype    = ATYPE_IPV6;
                        addr_len = IPV6_LEN;
                    end
                    if (!connect_ok)
                    begin
                        parse_phase = PH_IDLE;
                        push_reply(REP_BAD_CMD);
                    end
                    else
                    begin
                        addr_count  = 8'd0;
                        parse_phase = (atype == ATYPE_DOMAIN) ? PH_DLEN : PH_ADDR;
                    end
                end
            end
            PH_DLEN:
            begin
                addr_len    = b;
                addr_count  = 8'd0;
                parse_phase = (b == 8'd0) ? PH_PORTH : PH_ADDR;
            end
            PH_ADDR:
            begin
                push_result(KIND_ADDR, b, addr_count, atype, 16'd0, 1'b1);
                addr_count = addr_count + 8'd1;
                if (addr_count == addr_len)
                    parse_phase = PH_PORTH;
            end
            PH_PORTH:
            begin
                port_hi     = b;
                parse_phase = PH_PORTL;
            end
            PH_PORTL:
            begin
                push_result(KIND_TARGET, 8'd0, addr_len, atype, {port_hi, b}, 1'b1);
                parse_phase = PH_IDLE;
            end
            default:
                parse_phase = PH_IDLE;
        endcase
    endtask

    task automatic push_item(input logic [7:0] b, input logic restart, input bit counted = 1'b1);
        client_byte_t c;
        c.data    = b;
        c.restart = restart;
        client_bytes.push_back(c);
        if (counted)
            item_count++;
    endtask

    // one client session: mostly well formed, sometimes cut short or carrying bad codes
    task automatic add_session();
        logic [7:0] s[$];
        int         nm;
        int         pick;
        int         len;
        int         sel;
        int         cut;
        s.push_back(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : SOCKS_VER);
        if ($urandom_range(0, 49) == 0)
            nm = 0;
        else if ($urandom_range(0, 39) == 0)
            nm = $urandom_range(5, 255);
        else
            nm = $urandom_range(1, 4);
        s.push_back(8'(nm));
        pick = (nm == 0 || $urandom_range(0, 5) == 0) ? -1 : $urandom_range(0, nm - 1);
        for (int i = 0; i < nm; i++)
            s.push_back((i == pick) ? METHOD_NO_AUTH : 8'($urandom_range(0, 255)));
        s.push_back(8'($urandom_range(0, 255)));
        s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CMD_CONNECT);
        s.push_back(8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 11);
        len = 0;
        if (sel < 4)
        begin
            s.push_back(ATYP_CODE_IPV4);
            len = 4;
        end
        else if (sel < 8)
        begin
            s.push_back(ATYP_CODE_NAME);
            len = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 12);
            s.push_back(8'(len));
        end
        else if (sel < 11)
        begin
            s.push_back(ATYP_CODE_IPV6);
            len = 16;
        end
        else
            s.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
            s.push_back(8'($urandom_range(0, 255)));
        s.push_back(8'($urandom_range(0, 255)));
        s.push_back(8'($urandom_range(0, 255)));
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, s.size()) : s.size();
        for (int i = 0; i < cut; i++)
            push_item(s[i], i == 0);
        // trailing bytes are not counted as items; the parser drops them unless the session was cut short
        for (int i = $urandom_range(0, 2); i > 0; i--)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    // sender: advance on acceptance, hold a stalled item
    always @(negedge clk)
    begin
        client_byte_t c;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (client_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 13))
            begin
                c = client_bytes.pop_front();
                in_valid      <= 1'b1;
                data_byte     <= c.data;
                begin_session <= c.restart;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (cycle_count == HOLD_START)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                parse_client_byte(data_byte, begin_session);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind 0x%0h value 0x%0h", kind, value);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("value", 16'(want.value), 16'(value));
                    check_field("addr_index", 16'(want.addr_index), 16'(addr_index));
                    check_field("addr_type", 16'(want.addr_type), 16'(addr_type));
                    check_field("port", want.port, port);
                    check_field("last", 16'(want.last), 16'(last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** socks5_connect_handshake_parser_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        // bad version at the low extreme
        push_item(8'h00, 1'b1);
        // empty method list
        push_item(SOCKS_VER, 1'b1); push_item(8'h00, 1'b0);
        // unknown address type wins over a bad command
        push_item(SOCKS_VER, 1'b1); push_item(8'h01, 1'b0); push_item(METHOD_NO_AUTH, 1'b0);
        push_item(8'hFF, 1'b0); push_item(8'h02, 1'b0); push_item(8'hFF, 1'b0);
        push_item(8'h02, 1'b0);
        // command not CONNECT, valid address type
        push_item(SOCKS_VER, 1'b1); push_item(8'h01, 1'b0); push_item(METHOD_NO_AUTH, 1'b0);
        push_item(8'h00, 1'b0); push_item(8'h00, 1'b0); push_item(8'h00, 1'b0);
        push_item(ATYP_CODE_NAME, 1'b0);
        // zero-length domain, highest port, then a stray byte
        push_item(SOCKS_VER, 1'b1); push_item(8'h01, 1'b0); push_item(METHOD_NO_AUTH, 1'b0);
        push_item(8'h05, 1'b0); push_item(CMD_CONNECT, 1'b0); push_item(8'h00, 1'b0);
        push_item(ATYP_CODE_NAME, 1'b0); push_item(8'h00, 1'b0); push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0); push_item(8'hFF, 1'b0, 1'b0);

        item_count = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
                add_session();
            else
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (client_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** socks5_connect_handshake_parser_unit: PASSED **");
        else
        begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("** socks5_connect_handshake_parser_unit: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/socks5hp_pkg.sv
hw/rtl/socks5hp_parser.sv
hw/rtl/socks5_connect_handshake_parser_unit.sv
verif/socks5_connect_handshake_parser_unit_tb.sv
